FILE: rtl/core/twd_pkg.sv
// ---------------------------------------------------------------------------
// twd_pkg: shared types and codes of the trie word dictionary
// Item structures for both directions, command and result codes, and the
// default sizes of the node store.
// ---------------------------------------------------------------------------
`default_nettype none

package twd_pkg;

    // Default sizes of the node store.
    localparam int NODE_COUNT_DEF    = 4096;
    localparam int ALPHABET_SIZE_DEF = 32;

    // Command codes.
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;
    localparam logic [1:0] CMD_SPARE  = 2'd3;

    // Result codes; RC_OK also stands for "no failure" inside a word.
    localparam logic [1:0] RC_OK       = 2'd0;
    localparam logic [1:0] RC_NOT_WORD = 2'd1;
    localparam logic [1:0] RC_MISSING  = 2'd2;
    localparam logic [1:0] RC_FULL     = 2'd3;

    // One input item: a symbol of a word.
    typedef struct packed {
        logic [1:0] command;
        logic [4:0] symbol;
        logic       has_symbol;
        logic       last;
    } t_in_item;

    // One result item: the outcome of a finished word.
    typedef struct packed {
        logic [1:0] done_command;
        logic [1:0] result_code;
    } t_out_item;

endpackage

`default_nettype wire

FILE: rtl/core/twd_ram.sv
// ---------------------------------------------------------------------------
// twd_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; the read data is registered, so it
// appears in the cycle after the address.
// ---------------------------------------------------------------------------
`default_nettype none

module twd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port; addresses beyond the depth are dropped.
    always_ff @(posedge i_clk) begin
        if (i_we && (32'(i_waddr) < DEPTH)) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/core/trie_word_dictionary_core.sv
// ---------------------------------------------------------------------------
// trie_word_dictionary_core: word dictionary held as a prefix trie
// Words arrive one symbol per item; each follows, or on insert allocates, a
// child link in the link memory. The final item reports one result and, if
// the word is intact, sets, clears or reads the end mark of the node reached.
// ---------------------------------------------------------------------------
//
//  Channel   Ports                      Handshake
//  --------  -------------------------  ---------------------------------
//  input     i_item (t_in_item)         taken when start = 1 and busy = 0
//  result    o_result (t_out_item)      valid for one cycle while o_done = 1
//
//  An item with a symbol to follow first reads the child link from the link
//  memory, then follows or allocates it. An item without a symbol, or one
//  that arrives after its word has failed, is done in S_IDLE alone. A final
//  item of a search that has not failed then reads its end mark in S_MARK.
//  The result appears in the cycle after the word's work ends.
//  After reset a clearing pass writes every link and end mark to zero, with
//  busy high until it ends.
//  The receiver cannot stall, so o_done never waits.
// ---------------------------------------------------------------------------
`default_nettype none

module trie_word_dictionary_core #(
    parameter int NODE_COUNT    = twd_pkg::NODE_COUNT_DEF,
    parameter int ALPHABET_SIZE = twd_pkg::ALPHABET_SIZE_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire twd_pkg::t_in_item i_item,
    output logic                   busy,
    output logic                   o_done,
    output twd_pkg::t_out_item     o_result
);

    import twd_pkg::*;

    localparam int NW         = $clog2(NODE_COUNT);
    localparam int UW         = NW + 1;
    localparam int LINK_DEPTH = NODE_COUNT * ALPHABET_SIZE;
    localparam int AW         = $clog2(LINK_DEPTH);

    localparam logic [AW-1:0] ALPH_W    = AW'(ALPHABET_SIZE);
    localparam logic [AW-1:0] SWEEP_END = AW'(LINK_DEPTH - 1);
    localparam logic [UW-1:0] NODE_MAX  = UW'(NODE_COUNT);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LINK,
        S_MARK
    } t_state;

    // Control and word state.
    t_state          r_state, n_state;
    logic [AW-1:0]   r_sweep, n_sweep;
    logic [UW-1:0]   r_used, n_used;
    logic [NW-1:0]   r_cur, n_cur;
    logic [1:0]      r_fail, n_fail;
    logic            r_active, n_active;
    logic [1:0]      r_cmd, n_cmd;
    logic            r_out_valid, n_out_valid;

    // Payload registers.
    t_out_item       r_out, n_out;
    logic [AW-1:0]   r_addr, n_addr;
    logic            r_last, n_last;

    // Memory ports.
    logic            link_we;
    logic [AW-1:0]   link_waddr;
    logic [NW-1:0]   link_wdata;
    logic [AW-1:0]   link_raddr;
    logic [NW-1:0]   link_rdata;
    logic            mark_we;
    logic [NW-1:0]   mark_waddr;
    logic [0:0]      mark_wdata;
    logic [NW-1:0]   mark_raddr;
    logic [0:0]      mark_rdata;

    // Per-item working values.
    logic [1:0]      cmd_eff;
    logic [1:0]      fail_eff;
    logic [NW-1:0]   cur_eff;
    logic [NW-1:0]   next_node;
    logic [1:0]      link_fail;
    logic            fin_go;
    logic [NW-1:0]   fin_node;
    logic [1:0]      fin_fail;

    // Child links, one row of ALPHABET_SIZE entries per node.
    twd_ram #(
        .WIDTH (NW),
        .DEPTH (LINK_DEPTH)
    ) u_links (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    // End marks, one bit per node.
    twd_ram #(
        .WIDTH (1),
        .DEPTH (NODE_COUNT)
    ) u_marks (
        .i_clk   (i_clk),
        .i_we    (mark_we),
        .i_waddr (mark_waddr),
        .i_wdata (mark_wdata),
        .i_raddr (mark_raddr),
        .o_rdata (mark_rdata)
    );

    // Word context for an accepted item: a fresh word starts at the root.
    always_comb begin
        if (r_active) begin
            cmd_eff  = r_cmd;
            fail_eff = r_fail;
            cur_eff  = r_cur;
        end else begin
            cmd_eff  = (i_item.command == CMD_SPARE) ? CMD_SEARCH : i_item.command;
            fail_eff = RC_OK;
            cur_eff  = '0;
        end
    end

    // Link address of the symbol under the current node.
    assign link_raddr = AW'(cur_eff) * ALPH_W + AW'(i_item.symbol);

    // Outcome of a link read: follow, allocate, or fail.
    always_comb begin
        next_node = link_rdata;
        link_fail = RC_OK;
        if (link_rdata == '0) begin
            if (r_cmd != CMD_INSERT) begin
                link_fail = RC_MISSING;
            end else if (r_used >= NODE_MAX) begin
                link_fail = RC_FULL;
            end else begin
                next_node = NW'(r_used);
            end
        end
    end

    // Sequencer: next state, memory writes and the finish of a word.
    always_comb begin
        n_state     = r_state;
        n_sweep     = r_sweep;
        n_used      = r_used;
        n_cur       = r_cur;
        n_fail      = r_fail;
        n_active    = r_active;
        n_cmd       = r_cmd;
        n_out_valid = 1'b0;
        n_out       = r_out;
        n_addr      = r_addr;
        n_last      = r_last;
        link_we     = 1'b0;
        link_waddr  = r_addr;
        link_wdata  = NW'(r_used);
        mark_we     = 1'b0;
        mark_waddr  = r_cur;
        mark_wdata  = 1'b0;
        mark_raddr  = r_cur;
        fin_go      = 1'b0;
        fin_node    = r_cur;
        fin_fail    = r_fail;

        case (r_state)
            S_CLEAR: begin
                link_we    = 1'b1;
                link_waddr = r_sweep;
                link_wdata = '0;
                mark_we    = 1'b1;
                mark_waddr = r_sweep[NW-1:0];
                n_sweep    = r_sweep + AW'(1);
                if (r_sweep == SWEEP_END) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_active = 1'b1;
                    n_cmd    = cmd_eff;
                    n_fail   = fail_eff;
                    n_cur    = cur_eff;
                    n_last   = i_item.last;
                    fin_node = cur_eff;
                    fin_fail = fail_eff;
                    if (i_item.has_symbol && (fail_eff == RC_OK)) begin
                        if (9'(i_item.symbol) >= 9'(ALPHABET_SIZE)) begin
                            // A symbol outside the alphabet has no path.
                            n_fail   = RC_MISSING;
                            fin_fail = RC_MISSING;
                            fin_go   = i_item.last;
                        end else begin
                            n_addr  = link_raddr;
                            n_state = S_LINK;
                        end
                    end else begin
                        fin_go = i_item.last;
                    end
                end
            end
            S_LINK: begin
                n_state  = S_IDLE;
                n_fail   = link_fail;
                fin_fail = link_fail;
                fin_node = next_node;
                if (link_fail == RC_OK) begin
                    n_cur = next_node;
                    if (link_rdata == '0) begin
                        link_we = 1'b1;
                        n_used  = r_used + UW'(1);
                    end
                end
                fin_go = r_last;
            end
            S_MARK: begin
                n_out_valid        = 1'b1;
                n_out.done_command = r_cmd;
                n_out.result_code  = mark_rdata[0] ? RC_OK : RC_NOT_WORD;
                n_state            = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // End of a word: update or read the end mark and report.
        if (fin_go) begin
            n_active           = 1'b0;
            n_cur              = '0;
            n_fail             = RC_OK;
            mark_waddr         = fin_node;
            mark_raddr         = fin_node;
            n_out.done_command = n_cmd;
            if (fin_fail != RC_OK) begin
                n_out_valid       = 1'b1;
                n_out.result_code = fin_fail;
            end else if (n_cmd == CMD_INSERT) begin
                mark_we           = 1'b1;
                mark_wdata        = 1'b1;
                n_out_valid       = 1'b1;
                n_out.result_code = RC_OK;
            end else if (n_cmd == CMD_REMOVE) begin
                mark_we           = 1'b1;
                mark_wdata        = 1'b0;
                n_out_valid       = 1'b1;
                n_out.result_code = RC_OK;
            end else begin
                n_state = S_MARK;
            end
        end
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_sweep     <= '0;
            r_used      <= UW'(1);
            r_cur       <= '0;
            r_fail      <= RC_OK;
            r_active    <= 1'b0;
            r_cmd       <= CMD_INSERT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_used      <= n_used;
            r_cur       <= n_cur;
            r_fail      <= n_fail;
            r_active    <= n_active;
            r_cmd       <= n_cmd;
            r_out_valid <= n_out_valid;
        end
        r_out  <= n_out;
        r_addr <= n_addr;
        r_last <= n_last;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

FILE: test/tb_trie_word_dictionary_core.sv
// ---------------------------------------------------------------------------
// tb_trie_word_dictionary_core: self-checking bench for the trie dictionary
// Drives words one item at a time through the start/busy handshake and checks
// every strobed outcome against a trie predictor kept in the bench, or
// against a directed row's own result where it gives one. A short directed
// table comes first, then random words drawn partly from inserted words.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_trie_word_dictionary_core;

    timeunit 1ns;
    timeprecision 1ps;

    import twd_pkg::*;

    localparam int NODES    = NODE_COUNT_DEF;
    localparam int ALPH     = ALPHABET_SIZE_DEF;
    localparam int WORD_MAX = 16;
    localparam int BANK     = 64;
    localparam int DIR_ROWS = 26;

    // One row of the directed table; res is used only where typed is set.
    typedef struct packed {
        t_in_item  item;
        logic      typed;
        t_out_item res;
    } t_dir_row;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_in_item  i_item  = '0;
    logic      busy;
    logic      o_done;
    t_out_item o_result;

    trie_word_dictionary_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow copy of the trie.
    logic [11:0] link_mem [NODES*ALPH];
    logic        mark_mem [NODES];
    int          alloc_count;
    logic [11:0] cur_node;
    logic [1:0]  word_fail;
    logic        word_open;
    logic [1:0]  word_cmd;

    t_out_item   expected_outcomes [$];
    int          fault_count;
    int          items_sent;
    int          words_by_cmd [4];
    int          words_by_code [4];

    // Word under construction, and a bank of inserted words for reuse.
    logic [4:0]  word_buf [WORD_MAX];
    logic [4:0]  bank_sym [BANK][16];
    int          bank_len [BANK];
    int          bank_count;
    logic        no_idle;

    // Directed words: empty words, both ends of the alphabet, ignored
    // commands and blank items inside words, the spare command, and the
    // symbols that follow a failure.
    t_dir_row dir_table [DIR_ROWS] = '{
        '{'{CMD_SEARCH, 5'd0,  1'b0, 1'b1}, 1'b1, '{CMD_SEARCH, RC_NOT_WORD}},
        '{'{CMD_REMOVE, 5'd0,  1'b0, 1'b1}, 1'b1, '{CMD_REMOVE, RC_OK}},
        '{'{CMD_SEARCH, 5'd0,  1'b1, 1'b1}, 1'b1, '{CMD_SEARCH, RC_MISSING}},
        '{'{CMD_REMOVE, 5'd31, 1'b1, 1'b1}, 1'b1, '{CMD_REMOVE, RC_MISSING}},
        '{'{CMD_INSERT, 5'd0,  1'b1, 1'b0}, 1'b0, '0},
        '{'{CMD_SEARCH, 5'd31, 1'b1, 1'b1}, 1'b1, '{CMD_INSERT, RC_OK}},
        '{'{CMD_SEARCH, 5'd0,  1'b1, 1'b0}, 1'b0, '0},
        '{'{CMD_INSERT, 5'd31, 1'b1, 1'b1}, 1'b0, '0},
        '{'{CMD_SEARCH, 5'd0,  1'b1, 1'b1}, 1'b0, '0},
        '{'{CMD_REMOVE, 5'd0,  1'b1, 1'b1}, 1'b0, '0},
        '{'{CMD_SPARE,  5'd0,  1'b1, 1'b0}, 1'b0, '0},
        '{'{CMD_REMOVE, 5'd31, 1'b1, 1'b1}, 1'b1, '{CMD_SEARCH, RC_OK}},
        '{'{CMD_SEARCH, 5'd0,  1'b1, 1'b0}, 1'b0, '0},
        '{'{CMD_SEARCH, 5'd7,  1'b0, 1'b0}, 1'b0, '0},
        '{'{CMD_INSERT, 5'd31, 1'b1, 1'b1}, 1'b0, '0},
        '{'{CMD_SEARCH, 5'd0,  1'b1, 1'b0}, 1'b0, '0},
        '{'{CMD_SEARCH, 5'd9,  1'b0, 1'b1}, 1'b0, '0},
        '{'{CMD_SEARCH, 5'd5,  1'b1, 1'b0}, 1'b0, '0},
        '{'{CMD_SEARCH, 5'd0,  1'b1, 1'b0}, 1'b0, '0},
        '{'{CMD_SEARCH, 5'd31, 1'b1, 1'b1}, 1'b1, '{CMD_SEARCH, RC_MISSING}},
        '{'{CMD_INSERT, 5'd17, 1'b0, 1'b1}, 1'b1, '{CMD_INSERT, RC_OK}},
        '{'{CMD_SEARCH, 5'd0,  1'b0, 1'b1}, 1'b0, '0},
        '{'{CMD_REMOVE, 5'd0,  1'b1, 1'b0}, 1'b0, '0},
        '{'{CMD_SEARCH, 5'd31, 1'b1, 1'b1}, 1'b0, '0},
        '{'{CMD_SEARCH, 5'd0,  1'b1, 1'b0}, 1'b0, '0},
        '{'{CMD_SEARCH, 5'd31, 1'b1, 1'b1}, 1'b0, '0}
    };

    function automatic t_in_item make_item(logic [1:0] c, logic [4:0] s, logic h, logic l);
        t_in_item it;
        it.command    = c;
        it.symbol     = s;
        it.has_symbol = h;
        it.last       = l;
        return it;
    endfunction

    // Advances the shadow trie by one item; returns 1 when the item ends a
    // word, with the outcome of that word in res.
    function automatic logic predict_word_item(input t_in_item it, output t_out_item res);
        int          slot;
        logic [11:0] next;
        logic [1:0]  code;
        res = '0;
        if (!word_open) begin
            word_open = 1'b1;
            word_cmd  = (it.command == CMD_SPARE) ? CMD_SEARCH : it.command;
            cur_node  = '0;
            word_fail = RC_OK;
        end
        if (it.has_symbol && word_fail == RC_OK) begin
            if (int'(it.symbol) >= ALPH) begin
                word_fail = RC_MISSING;
            end else begin
                slot = int'(cur_node) * ALPH + int'(it.symbol);
                next = link_mem[slot];
                if (next == '0) begin
                    if (word_cmd != CMD_INSERT) begin
                        word_fail = RC_MISSING;
                    end else if (alloc_count >= NODES) begin
                        word_fail = RC_FULL;
                    end else begin
                        next = alloc_count[11:0];
                        alloc_count++;
                        link_mem[slot] = next;
                    end
                end
                if (word_fail == RC_OK) cur_node = next;
            end
        end
        if (!it.last) return 1'b0;
        if (word_fail != RC_OK) begin
            code = word_fail;
        end else if (word_cmd == CMD_INSERT) begin
            mark_mem[cur_node] = 1'b1;
            code = RC_OK;
        end else if (word_cmd == CMD_REMOVE) begin
            mark_mem[cur_node] = 1'b0;
            code = RC_OK;
        end else begin
            code = mark_mem[cur_node] ? RC_OK : RC_NOT_WORD;
        end
        res.done_command = word_cmd;
        res.result_code  = code;
        word_open = 1'b0;
        cur_node  = '0;
        word_fail = RC_OK;
        return 1'b1;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // Offers one item, waits until it is taken and records its outcome.
    task automatic send_item(input t_in_item it, input logic typed, input t_out_item typed_res);
        int        gap;
        t_out_item res;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        items_sent++;
        if (predict_word_item(it, res)) begin
            if (typed) res = typed_res;
            expected_outcomes.push_back(res);
            words_by_cmd[res.done_command]++;
            words_by_code[res.result_code]++;
        end
    endtask

    // Sends the first len symbols of word_buf as one word, with the odd blank
    // item inside it and sometimes a blank final item.
    task automatic send_word(input logic [1:0] cmd, input int len);
        logic first;
        logic tail_blank;
        first   = 1'b1;
        no_idle = ($urandom_range(0, 4) == 0);
        if (len == 0) begin
            send_item(make_item(cmd, 5'($urandom), 1'b0, 1'b1), 1'b0, '0);
        end else begin
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 11) == 0) begin
                    send_item(make_item(first ? cmd : 2'($urandom), 5'($urandom), 1'b0, 1'b0),
                              1'b0, '0);
                    first = 1'b0;
                end
                tail_blank = (i == len - 1) && ($urandom_range(0, 7) == 0);
                send_item(make_item(first ? cmd : 2'($urandom), word_buf[i], 1'b1,
                                    (i == len - 1) && !tail_blank), 1'b0, '0);
                first = 1'b0;
                if (tail_blank)
                    send_item(make_item(2'($urandom), 5'($urandom), 1'b0, 1'b1), 1'b0, '0);
            end
        end
    endtask

    // Random word: half of them reuse, cut or extend a word already
    // inserted, the rest are fresh and mostly from a few symbols so that
    // paths meet.
    task automatic send_random_word();
        int          r;
        int          len;
        int          k;
        logic [1:0]  cmd;
        logic        narrow;
        r = $urandom_range(0, 9);
        cmd = (r < 4) ? CMD_INSERT : (r < 6) ? CMD_REMOVE : (r < 9) ? CMD_SEARCH : CMD_SPARE;
        if (bank_count > 0 && $urandom_range(0, 1) == 1) begin
            k   = $urandom_range(0, bank_count - 1);
            len = bank_len[k];
            for (int i = 0; i < len; i++) word_buf[i] = bank_sym[k][i];
            r = $urandom_range(0, 3);
            if (r == 1 && len > 0) begin
                len--;
            end else if (r == 2 && len < 15) begin
                word_buf[len] = 5'($urandom);
                len++;
            end
        end else begin
            if ($urandom_range(0, 9) == 0) len = 0;
            else if ($urandom_range(0, 15) == 0) len = $urandom_range(7, 14);
            else len = $urandom_range(1, 5);
            narrow = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < len; i++)
                word_buf[i] = narrow ? 5'($urandom_range(0, 3)) : 5'($urandom);
        end
        if (cmd == CMD_INSERT) begin
            if (bank_count < BANK) begin
                k = bank_count;
                bank_count++;
            end else begin
                k = $urandom_range(0, BANK - 1);
            end
            bank_len[k] = len;
            for (int i = 0; i < len; i++) bank_sym[k][i] = word_buf[i];
        end
        send_word(cmd, len);
    endtask

    // Outcome checker: each strobe is matched with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_done) begin
            if (expected_outcomes.size() == 0) begin
                if (fault_count < 10)
                    $display("unexpected outcome: cmd %0d code %0d",
                             o_result.done_command, o_result.result_code);
                fault_count++;
            end else begin
                want = expected_outcomes.pop_front();
                if (o_result.done_command !== want.done_command ||
                    o_result.result_code !== want.result_code) begin
                    if (fault_count < 10)
                        $display("outcome mismatch: cmd exp %0d got %0d, code exp %0d got %0d",
                                 want.done_command, o_result.done_command,
                                 want.result_code, o_result.result_code);
                    fault_count++;
                end
            end
        end
    end

    initial begin
        int waited;
        for (int i = 0; i < NODES * ALPH; i++) link_mem[i] = '0;
        for (int i = 0; i < NODES; i++) mark_mem[i] = 1'b0;
        alloc_count = 1;
        cur_node    = '0;
        word_fail   = RC_OK;
        word_open   = 1'b0;
        word_cmd    = CMD_INSERT;
        fault_count = 0;
        items_sent  = 0;
        bank_count  = 0;
        no_idle     = 1'b0;
        for (int i = 0; i < 4; i++) begin
            words_by_cmd[i]  = 0;
            words_by_code[i] = 0;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table.
        for (int i = 0; i < DIR_ROWS; i++) begin
            no_idle = ($urandom_range(0, 2) == 0);
            send_item(dir_table[i].item, dir_table[i].typed, dir_table[i].res);
        end

        // Random words against a store with room to spare.
        while (items_sent < DIR_ROWS + 1700) send_random_word();
        start <= 1'b0;

        waited = 0;
        while (expected_outcomes.size() != 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        if (expected_outcomes.size() != 0) begin
            if (fault_count < 10)
                $display("%0d outcomes never arrived", expected_outcomes.size());
            fault_count += expected_outcomes.size();
        end

        $display("covered %0d items: %0d inserts, %0d removes, %0d searches, %0d nodes in use",
                 items_sent, words_by_cmd[CMD_INSERT], words_by_cmd[CMD_REMOVE],
                 words_by_cmd[CMD_SEARCH], alloc_count);
        $display("outcomes: %0d ok, %0d not a word, %0d missing, %0d store full",
                 words_by_code[RC_OK], words_by_code[RC_NOT_WORD],
                 words_by_code[RC_MISSING], words_by_code[RC_FULL]);
        if (fault_count == 0) begin
            $display("tb_trie_word_dictionary_core: clean");
        end else begin
            $display("tb_trie_word_dictionary_core: errors");
        end
        $finish;
    end

    // Watchdog: covers the clearing pass and the slowest run several times.
    initial begin
        #3_000_000;
        $display("tb_trie_word_dictionary_core: errors");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/core/twd_pkg.sv
rtl/core/twd_ram.sv
rtl/core/trie_word_dictionary_core.sv
test/tb_trie_word_dictionary_core.sv
